@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, held off during reset
`define ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, held off during reset
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/tccw_pkg.sv @@
`default_nettype none

package tccw_pkg;

    // grid defaults
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [2:0]        TAB_STOP   = 3'd4;

    // input opcodes
    localparam logic OP_PUT       = 1'b0;
    localparam logic OP_BACKSPACE = 1'b1;

    // result actions
    localparam logic ACT_CELL   = 1'b0;
    localparam logic ACT_SCROLL = 1'b1;

    // register file
    localparam int                APB_ADDR_W = 3;
    localparam logic              REG_ATTRIBUTE = 1'b0;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_BACKSPACE,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CELL,
        BK_SCROLL
    } bk_state_t;

endpackage

`default_nettype wire

@@ rtl/core/text_console_cursor_writer_top.sv @@
// Text console cursor writer. Input words carry a character in tdata[7:0]
// and the opcode (set for backspace) in tuser[0]; output words are cell
// writes or scroll-up commands for a COLUMNS x ROWS text grid, with row,
// column and cell data in tdata, the action in tuser[0] and tlast on the
// final word of each input. The front classifies each input word as it is
// accepted and places it in a two-entry command queue. The back sequencer
// emits at most one result word per cycle, and a word waits in the output
// register while the receiver stalls. Backspace and newline are handled
// as they leave the queue and return gives no result; a printable byte or
// a tab is fetched and then written as cells (one cell, or a space per cell
// up to the next tab stop), with a scroll when a cell wraps past the last row.
// The attribute register (offset 0x0) sets the high byte of every cell and
// resets to 0x07; write it only while the block is idle.

`default_nettype none

module text_console_cursor_writer_top
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] char_code
    input  wire logic [0:0]            s_tuser,   // [0] opcode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [4:0] row, [11:5] col, [27:12] cell_data,
                                                  // [31:28] zero
    output logic [0:0]                 m_tuser,   // [0] action
    output logic                       m_tlast,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              reg_sel;
    logic              q_full;
    logic              q_push;
    cmd_t              q_cmd;
    logic              q_not_empty;
    logic              q_pop;
    cmd_t              q_head;

    // attribute register
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_ATTRIBUTE);
    assign attr_next = (psel && penable && pwrite && reg_sel) ?
                       pwdata[ATTR_W-1:0] : attr_reg;
    assign prdata    = reg_sel ? {24'd0, attr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // front: accept and classify
    tccw_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // command queue
    tccw_cmdq u_cmdq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    // back: cursor sequencer and output register
    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .attribute (attr_reg),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/tccw_front.sv @@
`default_nettype none

module tccw_front
    import tccw_pkg::*;
(
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] char_code
    input  wire logic [0:0]        s_tuser,   // [0] opcode
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    // accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify the incoming word
    always_comb
    begin
        q_cmd.ch = s_tdata;
        if (s_tuser[0] == OP_BACKSPACE)
        begin
            q_cmd.kind = CMD_BACKSPACE;
        end
        else
        begin
            case (s_tdata)
                CH_NEWLINE: q_cmd.kind = CMD_NEWLINE;
                CH_RETURN:  q_cmd.kind = CMD_RETURN;
                CH_TAB:     q_cmd.kind = CMD_TAB;
                default:    q_cmd.kind = CMD_PUT;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tccw_cmdq.sv @@
`default_nettype none

module tccw_cmdq
    import tccw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(CMDQ_DEPTH - 1);
    localparam logic [AW:0]   CNT_FULL = (AW+1)'(CMDQ_DEPTH);

    cmd_t           entry_reg [CMDQ_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tccw_back.sv @@
`default_nettype none

module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ATTR_W-1:0] attribute,
    input  wire logic              cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [4:0] row, [11:5] col, [27:12] cell_data,
                                              // [31:28] zero
    output logic [0:0]             m_tuser,   // [0] action
    output logic                   m_tlast
);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    bk_state_t          state_reg, state_next;
    logic [ROW_W-1:0]   line_reg, line_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_action_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic               out_last_reg;

    logic               slot_free;
    logic               emit;
    logic               e_action;
    logic [ROW_W-1:0]   e_row;
    logic [COL_W-1:0]   e_col;
    logic [CHAR_W-1:0]  e_ch;
    logic               e_last;
    logic               wrap;
    logic               wrap_scroll;

    assign slot_free   = !out_valid_reg || m_tready;
    assign wrap        = (col_reg == COL_LAST);
    assign wrap_scroll = wrap && (line_reg == ROW_LAST);

    // sequencer: at most one result word per cycle, while the output slot is free
    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        e_action   = ACT_CELL;
        e_row      = line_reg;
        e_col      = col_reg;
        e_ch       = CH_SPACE;
        e_last     = 1'b1;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                            else if (line_reg != '0)
                            begin
                                line_next = line_reg - 1'b1;
                                col_next  = COL_LAST;
                            end
                            emit  = 1'b1;
                            e_row = line_next;
                            e_col = col_next;
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (line_reg == ROW_LAST)
                            begin
                                emit     = 1'b1;
                                e_action = ACT_SCROLL;
                                e_row    = '0;
                                e_col    = '0;
                            end
                            else
                            begin
                                line_next = line_reg + 1'b1;
                            end
                        end
                        CMD_RETURN:
                        begin
                            col_next = '0;
                        end
                        CMD_TAB:
                        begin
                            cnt_next   = TAB_STOP - {1'b0, col_reg[1:0]};
                            ch_next    = CH_SPACE;
                            state_next = BK_CELL;
                        end
                        default:
                        begin
                            cnt_next   = 3'd1;
                            ch_next    = cmd.ch;
                            state_next = BK_CELL;
                        end
                    endcase
                end
            end
            BK_CELL:
            begin
                if (slot_free)
                begin
                    emit     = 1'b1;
                    e_ch     = ch_reg;
                    e_last   = (cnt_reg == 3'd1) && !wrap_scroll;
                    cnt_next = cnt_reg - 1'b1;
                    if (wrap)
                    begin
                        col_next = '0;
                        if (wrap_scroll)
                        begin
                            state_next = BK_SCROLL;
                        end
                        else
                        begin
                            line_next = line_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (!wrap_scroll && cnt_reg == 3'd1)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_SCROLL:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_action   = ACT_SCROLL;
                    e_row      = '0;
                    e_col      = '0;
                    e_last     = (cnt_reg == '0);
                    state_next = (cnt_reg == '0) ? BK_IDLE : BK_CELL;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            line_reg  <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

    // output register
    assign out_valid_next = slot_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit)
        begin
            out_action_reg <= e_action;
            out_row_reg    <= e_row;
            out_col_reg    <= e_col;
            out_cell_reg   <= {attribute, e_ch};
            out_last_reg   <= e_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_cell_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/tccw_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module tccw_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [31:0]           m_tdata,
    input wire logic [0:0]            m_tuser,
    input wire logic                  m_tlast,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [31:0]           pwdata,
    input wire logic [31:0]           prdata
);

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    logic        scroll_word;
    logic        scroll_blank;
    logic [33:0] out_word;
    logic        attr_sel;
    logic        attr_write;

    assign scroll_word  = m_tvalid && (m_tuser[0] == ACT_SCROLL);
    assign scroll_blank = (m_tdata[11:0] == 12'd0) && (m_tdata[19:12] == CH_SPACE);
    assign out_word     = {m_tuser, m_tlast, m_tdata};
    assign attr_sel     = (paddr[APB_ADDR_W-1:2] == REG_ATTRIBUTE);
    assign attr_write   = psel && penable && pwrite && attr_sel;

    // a scroll word carries position zero and a blank character
    `ASSERT_IMPL(a_scroll_blank, scroll_word, scroll_blank)

    // every cell position lies inside the grid
    `ASSERT_IMPL(a_cell_in_grid, m_tvalid, m_tdata[4:0] <= ROW_LAST && m_tdata[11:5] <= COL_LAST)

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

    // a written attribute reads back on the next cycle
    `ASSERT_NEXT(a_attr_readback, attr_write, !attr_sel || prdata[7:0] == $past(pwdata[7:0]))

endmodule

bind text_console_cursor_writer_top tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

`default_nettype wire

@@ dv/tb_text_console_cursor_writer_top.sv @@
`timescale 1ns / 1ps

module tb_text_console_cursor_writer_top;
    import tccw_pkg::*;

    localparam int GRID_COLS   = DEF_COLUMNS;
    localparam int GRID_ROWS   = DEF_ROWS;
    localparam int SETTLE_CYC  = 20;
    localparam int STALL_CYC   = 300;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = APB_ADDR_W'(4 * REG_ATTRIBUTE);

    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] ch;
    } key_t;

    typedef struct packed {
        logic              action;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_data;
        logic              last;
    } grid_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;     // [7:0] char_code
    logic [0:0]            s_tuser = '0;     // [0] opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;          // [4:0] row, [11:5] col, [27:12] cell_data
    logic [0:0]            m_tuser;          // [0] action
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    key_t       key_q[$];
    grid_word_t grid_words_q[$];
    grid_word_t held_word;
    bit         held_valid = 1'b0;

    // console state as predicted
    int                pred_line = 0;
    int                pred_column = 0;
    logic [ATTR_W-1:0] attr_reg = ATTR_RESET;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  stall_arm = 1'b0;
    int  stall_left = 0;
    int  errors = 0;

    text_console_cursor_writer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // hold back the previous word so the final one of an input can get its last flag
    task automatic emit_grid_word(input logic act, input int r, input int c,
                                  input logic [CHAR_W-1:0] ch);
        if (held_valid)
            grid_words_q.push_back(held_word);
        held_word  = '{act, r[ROW_W-1:0], c[COL_W-1:0], {attr_reg, ch}, 1'b0};
        held_valid = 1'b1;
    endtask

    task automatic advance_line();
        pred_column = 0;
        pred_line++;
        if (pred_line >= GRID_ROWS)
        begin
            pred_line = GRID_ROWS - 1;
            emit_grid_word(ACT_SCROLL, 0, 0, CH_SPACE);
        end
    endtask

    task automatic write_cell(input logic [CHAR_W-1:0] ch);
        emit_grid_word(ACT_CELL, pred_line, pred_column, ch);
        pred_column++;
        if (pred_column >= GRID_COLS)
            advance_line();
    endtask

    // result words caused by one accepted input word
    task automatic predict_grid_words(input logic opcode, input logic [CHAR_W-1:0] ch);
        int spaces;
        if (opcode == OP_BACKSPACE)
        begin
            if (pred_column > 0)
            begin
                pred_column--;
            end
            else if (pred_line > 0)
            begin
                pred_line--;
                pred_column = GRID_COLS - 1;
            end
            emit_grid_word(ACT_CELL, pred_line, pred_column, CH_SPACE);
        end
        else if (ch == CH_NEWLINE)
        begin
            advance_line();
        end
        else if (ch == CH_RETURN)
        begin
            pred_column = 0;
        end
        else if (ch == CH_TAB)
        begin
            spaces = int'(TAB_STOP) - (pred_column % int'(TAB_STOP));
            for (int i = 0; i < spaces; i++)
                write_cell(CH_SPACE);
        end
        else
        begin
            write_cell(ch);
        end
        if (held_valid)
        begin
            held_word.last = 1'b1;
            grid_words_q.push_back(held_word);
            held_valid = 1'b0;
        end
    endtask

    task automatic queue_key(input logic opcode, input logic [CHAR_W-1:0] ch);
        key_q.push_back('{opcode, ch});
    endtask

    // random text: bursts of newlines to reach the bottom, long runs to wrap
    task automatic queue_random_text(input int n_keys);
        int count;
        int run_len;
        int pick;
        count = 0;
        while (count < n_keys)
        begin
            if ($urandom_range(99) < 25)
            begin
                run_len = $urandom_range(2, 8);
                for (int i = 0; i < run_len; i++)
                    queue_key(OP_PUT, CH_NEWLINE);
            end
            else
            begin
                run_len = $urandom_range(4, 20);
                for (int i = 0; i < run_len; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        queue_key(OP_BACKSPACE, CHAR_W'($urandom_range(255)));
                    else if (pick < 35)
                        queue_key(OP_PUT, CH_TAB);
                    else if (pick < 40)
                        queue_key(OP_PUT, CH_RETURN);
                    else
                        queue_key(OP_PUT, CHAR_W'($urandom_range(255)));
                end
            end
            count += run_len;
        end
    endtask

    // wait until every input word is taken and every result word is back, then settle
    task automatic drain();
        @(negedge clk);
        while (key_q.size() != 0 || s_tvalid || grid_words_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_reg = value;
    endtask

    // input word driver
    always @(posedge clk or negedge rst_n)
    begin : key_driver
        key_t k;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (key_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                k = key_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= k.ch;
                s_tuser  <= k.opcode;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result word receiver with random and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_arm)
        begin
            stall_arm  <= 1'b0;
            stall_left <= STALL_CYC;
            m_tready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted input words, check accepted result words
    always @(posedge clk)
    begin : monitor
        grid_word_t want;
        grid_word_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_grid_words(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser[0], m_tdata[4:0], m_tdata[11:5], m_tdata[27:12], m_tlast};
                if (grid_words_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected act=%0d row=%0d col=%0d data=%h last=%0d",
                             $time, got.action, got.row, got.col, got.cell_data,
                             got.last);
                end
                else
                begin
                    want = grid_words_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected act=%0d row=%0d col=%0d data=%h last=%0d",
                                 $time, want.action, want.row, want.col, want.cell_data,
                                 want.last);
                        $display("%0t: actual   act=%0d row=%0d col=%0d data=%h last=%0d",
                                 $time, got.action, got.row, got.col, got.cell_data,
                                 got.last);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 19;
        recv_idle_pct = 58;

        // directed input words at the reset attribute
        queue_key(OP_BACKSPACE, 8'h00);   // backspace at home stays put
        queue_key(OP_PUT, 8'h41);
        queue_key(OP_PUT, 8'h00);
        queue_key(OP_PUT, 8'hFF);
        queue_key(OP_PUT, CH_TAB);        // one space to the stop
        queue_key(OP_PUT, CH_TAB);        // full four spaces
        queue_key(OP_PUT, 8'h1B);         // control byte written as is
        queue_key(OP_PUT, CH_NEWLINE);    // no word, no scroll
        queue_key(OP_BACKSPACE, 8'hFF);   // back to end of previous row
        queue_key(OP_PUT, 8'h7E);         // last column, wraps to next row
        queue_key(OP_PUT, 8'h80);
        queue_key(OP_PUT, CH_RETURN);     // no word
        queue_key(OP_PUT, CH_TAB);
        queue_key(OP_BACKSPACE, 8'h5A);
        queue_key(OP_PUT, 8'h7F);
        drain();

        // random text, one long receiver stall to back up the input
        write_attribute(8'hFF);
        queue_random_text(30);
        stall_arm <= 1'b1;
        drain();

        send_idle_pct = 58;
        recv_idle_pct = 19;
        write_attribute(8'h00);
        queue_random_text(30);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(ATTR_W'($urandom_range(1, 254)));
        queue_random_text(30);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
